// ===== hdl/fdf_pkg.sv =====
// shared types and constants for the flooding duplicate filter
// no dependencies; imported by every module of the block
`default_nettype none

package fdf_pkg;

    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF       = 16;

    localparam int MSG_ID_W = 16;
    localparam int TTL_W    = 8;
    localparam int HOPS_W   = 8;
    localparam int TTL_OUT_W = TTL_W + 1;

    typedef enum logic [1:0] {
        VERDICT_FWD      = 2'd0,
        VERDICT_DUP      = 2'd1,
        VERDICT_TTL_ZERO = 2'd2,
        VERDICT_TTL_NEG  = 2'd3
    } t_verdict;

    // search token that walks down the history chain
    typedef struct packed {
        logic run;
        logic hit;
    } t_probe;

endpackage

`default_nettype wire

// ===== hdl/flood_duplicate_filter_top.sv =====
// flooding relay forwarding filter: duplicate check against a chain of
// history cells, ttl decrement and hop increment; depends on fdf_pkg, fdf_cell
//
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_stall    | i_message_id, i_time_to_live, i_hops_so_far
//  output  | out       | o_out_valid / i_out_stall  | o_forward_now, o_verdict, o_first_arrival,
//          |           |                            | o_updated_ttl, o_updated_hops, o_echoed_id
//
// one item is in flight at a time: the next item is accepted only once the search
// token, walking one cell per cycle, has passed the whole chain and the result is out.
// synchronous active-low reset clears all valid bits at once, no clearing pass.
// the output register holds a finished item under stall while the block is
// free to accept the next one; a new result waits until that register frees.
`default_nettype none

module flood_duplicate_filter_top #(
    parameter int HISTORY_DEPTH = fdf_pkg::HISTORY_DEPTH_DEF,
    parameter int ID_BITS       = fdf_pkg::ID_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [fdf_pkg::MSG_ID_W-1:0]   i_message_id,
    input  wire logic [fdf_pkg::TTL_W-1:0]      i_time_to_live,
    input  wire logic [fdf_pkg::HOPS_W-1:0]     i_hops_so_far,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_forward_now,
    output logic [1:0]                          o_verdict,
    output logic                                o_first_arrival,
    output logic signed [fdf_pkg::TTL_OUT_W-1:0] o_updated_ttl,
    output logic [fdf_pkg::HOPS_W-1:0]          o_updated_hops,
    output logic [fdf_pkg::MSG_ID_W-1:0]        o_echoed_id
);
    import fdf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_inject;
    logic   r_hit;

    logic [MSG_ID_W-1:0] r_msg_id;
    logic [ID_BITS-1:0]  r_key;
    logic [TTL_W-1:0]    r_ttl;
    logic [HOPS_W-1:0]   r_hops;

    logic                 r_out_valid;
    logic                 r_out_fwd;
    t_verdict             r_out_verdict;
    logic                 r_out_first;
    logic [TTL_OUT_W-1:0] r_out_ttl;
    logic [HOPS_W-1:0]    r_out_hops;
    logic [MSG_ID_W-1:0]  r_out_id;

    logic                         in_accept;
    logic                         out_free;
    logic                         commit;
    logic [MSG_ID_W+ID_BITS-1:0]  id_ext;
    logic [ID_BITS-1:0]           n_key;
    t_verdict                     n_verdict;
    logic [TTL_OUT_W-1:0]         n_ttl;
    logic [HOPS_W-1:0]            n_hops;

    t_probe             probe    [HISTORY_DEPTH+1];
    logic [ID_BITS-1:0] sh_id    [HISTORY_DEPTH+1];
    logic               sh_valid [HISTORY_DEPTH+1];

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // key is the id truncated or zero-extended to the history width
    assign id_ext = {{ID_BITS{1'b0}}, i_message_id};
    assign n_key  = id_ext[ID_BITS-1:0];

    always_comb begin
        n_ttl  = {1'b0, r_ttl} - TTL_OUT_W'(1);
        n_hops = (r_hops == {HOPS_W{1'b1}}) ? r_hops : r_hops + HOPS_W'(1);
        if (r_hit) begin
            n_verdict = VERDICT_DUP;
        end else if (r_ttl > TTL_W'(1)) begin
            n_verdict = VERDICT_FWD;
        end else if (r_ttl == TTL_W'(1)) begin
            n_verdict = VERDICT_TTL_ZERO;
        end else begin
            n_verdict = VERDICT_TTL_NEG;
        end
    end

    // a forwarded id shifts into the head; the oldest entry drops off the tail
    assign commit = (r_state == S_FINISH) && out_free && (n_verdict == VERDICT_FWD);

    assign probe[0].run = r_inject;
    assign probe[0].hit = 1'b0;
    assign sh_id[0]     = r_key;
    assign sh_valid[0]  = 1'b1;

    for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
        fdf_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_key         (r_key),
            .i_probe       (probe[k]),
            .o_probe       (probe[k+1]),
            .i_shift       (commit),
            .i_shift_id    (sh_id[k]),
            .i_shift_valid (sh_valid[k]),
            .o_id          (sh_id[k+1]),
            .o_valid       (sh_valid[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inject    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_inject <= in_accept;
            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (probe[HISTORY_DEPTH].run) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end

        if (in_accept) begin
            r_msg_id <= i_message_id;
            r_key    <= n_key;
            r_ttl    <= i_time_to_live;
            r_hops   <= i_hops_so_far;
        end
        if ((r_state == S_SEARCH) && probe[HISTORY_DEPTH].run) begin
            r_hit <= probe[HISTORY_DEPTH].hit;
        end
        if ((r_state == S_FINISH) && out_free) begin
            r_out_fwd     <= (n_verdict == VERDICT_FWD);
            r_out_verdict <= n_verdict;
            r_out_first   <= !r_hit;
            r_out_ttl     <= n_ttl;
            r_out_hops    <= n_hops;
            r_out_id      <= r_msg_id;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_forward_now   = r_out_fwd;
    assign o_verdict       = r_out_verdict;
    assign o_first_arrival = r_out_first;
    assign o_updated_ttl   = r_out_ttl;
    assign o_updated_hops  = r_out_hops;
    assign o_echoed_id     = r_out_id;

endmodule

`default_nettype wire

// ===== hdl/fdf_cell.sv =====
// one history cell: holds a stored id and its valid bit, compares the probe
// key and passes the search token and its own contents to the next cell
// depends on fdf_pkg
`default_nettype none

module fdf_cell #(
    parameter int ID_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [ID_BITS-1:0] i_key,
    input  wire fdf_pkg::t_probe    i_probe,
    output fdf_pkg::t_probe         o_probe,
    input  wire logic               i_shift,
    input  wire logic [ID_BITS-1:0] i_shift_id,
    input  wire logic               i_shift_valid,
    output logic [ID_BITS-1:0]      o_id,
    output logic                    o_valid
);
    import fdf_pkg::*;

    logic [ID_BITS-1:0] r_id;
    logic               r_valid;
    t_probe             r_probe;
    t_probe             n_probe;

    always_comb begin
        n_probe.run = i_probe.run;
        n_probe.hit = i_probe.hit | (r_valid && (r_id == i_key));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_probe.run <= 1'b0;
        end else begin
            r_probe.run <= n_probe.run;
            if (i_shift) begin
                r_valid <= i_shift_valid;
            end
        end
        r_probe.hit <= n_probe.hit;
        if (i_shift) begin
            r_id <= i_shift_id;
        end
    end

    assign o_probe = r_probe;
    assign o_id    = r_id;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ===== hdl/fdf_checker.sv =====
// port-level checks for the flooding duplicate filter, bound to the top level
// depends on fdf_pkg and flood_duplicate_filter_top
`default_nettype none

module fdf_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire logic                            o_forward_now,
    input wire logic [1:0]                      o_verdict,
    input wire logic                            o_first_arrival,
    input wire logic signed [fdf_pkg::TTL_OUT_W-1:0] o_updated_ttl,
    input wire logic [fdf_pkg::HOPS_W-1:0]      o_updated_hops,
    input wire logic [fdf_pkg::MSG_ID_W-1:0]    o_echoed_id
);
    import fdf_pkg::*;

    // a stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped under stall");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_verdict) && $stable(o_echoed_id)
            && $stable(o_updated_ttl) && $stable(o_updated_hops))
        else $error("stalled output payload changed");

    // one item in flight: an accepted item closes the input for the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted again while searching");

    // forward flag and first-arrival flag agree with the verdict
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_forward_now == (o_verdict == VERDICT_FWD))
            && (o_first_arrival == (o_verdict != VERDICT_DUP)))
        else $error("verdict flags inconsistent");

    // ttl verdicts match the decremented ttl
    a_ttl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_verdict != VERDICT_TTL_ZERO) || (o_updated_ttl == 0))
            && ((o_verdict != VERDICT_TTL_NEG) || (o_updated_ttl == -1))
            && ((o_verdict != VERDICT_FWD) || (o_updated_ttl > 0)))
        else $error("ttl verdict does not match updated ttl");

endmodule

bind flood_duplicate_filter_top fdf_checker u_fdf_checker (.*);

`default_nettype wire

// ===== verif/tb_flood_duplicate_filter_top.sv =====
// testbench for flood_duplicate_filter_top: directed and random packet headers,
// each verdict checked against an in-bench duplicate history and ttl/hop rules
// depends on fdf_pkg and the block's rtl
`default_nettype none

module tb_flood_duplicate_filter_top;
    import fdf_pkg::*;

    localparam int HIST_DEPTH    = fdf_pkg::HISTORY_DEPTH_DEF;
    localparam int RANDOM_PER_PH = 425;
    localparam int NUM_PHASES    = 3;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [MSG_ID_W-1:0] id;
        logic [TTL_W-1:0]    ttl;
        logic [HOPS_W-1:0]   hops;
    } t_header;

    typedef struct {
        logic                        fwd;
        t_verdict                    verdict;
        logic                        first;
        logic signed [TTL_OUT_W-1:0] ttl;
        logic [HOPS_W-1:0]           hops;
        logic [MSG_ID_W-1:0]         id;
    } t_outcome;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [MSG_ID_W-1:0]         i_message_id = '0;
    logic [TTL_W-1:0]            i_time_to_live = '0;
    logic [HOPS_W-1:0]           i_hops_so_far = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic                        o_forward_now;
    logic [1:0]                  o_verdict;
    logic                        o_first_arrival;
    logic signed [TTL_OUT_W-1:0] o_updated_ttl;
    logic [HOPS_W-1:0]           o_updated_hops;
    logic [MSG_ID_W-1:0]         o_echoed_id;

    // predictor copy of the forwarding history
    logic [MSG_ID_W-1:0] hist_id [HIST_DEPTH];
    logic                hist_vld [HIST_DEPTH];
    int unsigned         hist_slot = 0;
    int unsigned         hist_wraps = 0;

    t_header     pending_headers [$];
    t_outcome    awaited_verdicts [$];
    t_header     next_header;
    t_outcome    oldest_verdict;
    int unsigned verdict_tally [4] = '{0, 0, 0, 0};
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned headers_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    logic [MSG_ID_W-1:0] id_pool_base = '0;

    flood_duplicate_filter_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_message_id    (i_message_id),
        .i_time_to_live  (i_time_to_live),
        .i_hops_so_far   (i_hops_so_far),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_forward_now   (o_forward_now),
        .o_verdict       (o_verdict),
        .o_first_arrival (o_first_arrival),
        .o_updated_ttl   (o_updated_ttl),
        .o_updated_hops  (o_updated_hops),
        .o_echoed_id     (o_echoed_id)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_id[k]  = '0;
            hist_vld[k] = 1'b0;
        end
    end

    // works out the verdict for one accepted header and updates the history
    task automatic judge_header(input t_header h);
        t_outcome o;
        logic     seen;
        int       ttl_next;
        seen = 1'b0;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            if (hist_vld[k] && hist_id[k] == h.id) begin
                seen = 1'b1;
            end
        end
        ttl_next = int'(h.ttl) - 1;
        // a duplicate outranks both ttl verdicts
        if (seen) begin
            o.verdict = VERDICT_DUP;
        end else if (ttl_next > 0) begin
            o.verdict = VERDICT_FWD;
        end else if (ttl_next == 0) begin
            o.verdict = VERDICT_TTL_ZERO;
        end else begin
            o.verdict = VERDICT_TTL_NEG;
        end
        o.fwd   = (o.verdict == VERDICT_FWD);
        o.first = !seen;
        o.ttl   = ttl_next[TTL_OUT_W-1:0];
        o.hops  = (h.hops == {HOPS_W{1'b1}}) ? h.hops : h.hops + HOPS_W'(1);
        o.id    = h.id;
        if (o.fwd) begin
            hist_id[hist_slot]  = h.id;
            hist_vld[hist_slot] = 1'b1;
            if (hist_slot == HIST_DEPTH - 1) begin
                hist_slot = 0;
                hist_wraps++;
            end else begin
                hist_slot++;
            end
        end
        verdict_tally[o.verdict]++;
        awaited_verdicts.push_back(o);
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         results_seen, field, want, got);
            end
        end
    endtask

    // mostly ids from a pool a bit larger than the history, so hits and evictions mix
    function automatic t_header random_header();
        t_header     h;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
            h.id = id_pool_base + MSG_ID_W'($urandom_range(HIST_DEPTH + 7));
        end else begin
            h.id = MSG_ID_W'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 12) begin
            h.ttl = '0;
        end else if (pick < 24) begin
            h.ttl = TTL_W'(1);
        end else if (pick < 30) begin
            h.ttl = '1;
        end else begin
            h.ttl = TTL_W'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            h.hops = '1;
        end else if (pick < 15) begin
            h.hops = {{(HOPS_W-1){1'b1}}, 1'b0};
        end else if (pick < 20) begin
            h.hops = '0;
        end else begin
            h.hops = HOPS_W'($urandom);
        end
        return h;
    endfunction

    // holds the sender back until every awaited verdict has come out
    task automatic wait_drained();
        while (pending_headers.size() > 0 || i_in_valid || awaited_verdicts.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                judge_header('{id: i_message_id, ttl: i_time_to_live, hops: i_hops_so_far});
                headers_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_headers.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_header = pending_headers.pop_front();
                    i_in_valid     <= 1'b1;
                    i_message_id   <= next_header.id;
                    i_time_to_live <= next_header.ttl;
                    i_hops_so_far  <= next_header.hops;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (awaited_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d: no item awaited, got id 0x%0h verdict %0d",
                                 results_seen, o_echoed_id, o_verdict);
                    end
                end else begin
                    oldest_verdict = awaited_verdicts.pop_front();
                    compare_field("forward_now", 32'(o_forward_now), 32'(oldest_verdict.fwd));
                    compare_field("verdict", 32'(o_verdict), 32'(oldest_verdict.verdict));
                    compare_field("first_arrival", 32'(o_first_arrival),
                                  32'(oldest_verdict.first));
                    compare_field("updated_ttl", {23'b0, o_updated_ttl},
                                  {23'b0, oldest_verdict.ttl});
                    compare_field("updated_hops", 32'(o_updated_hops),
                                  32'(oldest_verdict.hops));
                    compare_field("echoed_id", 32'(o_echoed_id), 32'(oldest_verdict.id));
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct  = 36;
        recv_stall_pct = 66;

        // extremes of the fields and the ttl edge cases
        pending_headers.push_back('{16'h0000, 8'hFF, 8'h00});
        pending_headers.push_back('{16'hFFFF, 8'h02, 8'hFF});
        pending_headers.push_back('{16'h0000, 8'h05, 8'hFE});
        pending_headers.push_back('{16'h1234, 8'h00, 8'h07});
        pending_headers.push_back('{16'h1234, 8'h01, 8'h08});
        // dropped ids left no trace, so this one goes out
        pending_headers.push_back('{16'h1234, 8'h03, 8'h09});
        // duplicates with the ttl about to run out
        pending_headers.push_back('{16'hFFFF, 8'h00, 8'hFF});
        pending_headers.push_back('{16'hFFFF, 8'h01, 8'h00});
        // fill the history past its end so the write slot wraps over the oldest
        for (int k = 0; k < HIST_DEPTH; k++) begin
            pending_headers.push_back('{16'h0100 + 16'(k), 8'h40, 8'(k)});
        end
        // evicted id counts as new again
        pending_headers.push_back('{16'h0000, 8'h09, 8'h80});
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 66;
                end
                1: begin
                    send_idle_pct  = 66;
                    recv_stall_pct = 36;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            id_pool_base = MSG_ID_W'($urandom);
            for (int n = 0; n < RANDOM_PER_PH; n++) begin
                pending_headers.push_back(random_header());
            end
            wait_drained();
        end

        repeat (HIST_DEPTH + 8) @(posedge i_clk);
        mismatches += awaited_verdicts.size();
        $display("%0d headers in, %0d verdicts out: %0d forwarded, %0d duplicates,",
                 headers_sent, results_seen, verdict_tally[VERDICT_FWD],
                 verdict_tally[VERDICT_DUP]);
        $display("%0d expired at zero, %0d below zero; history write slot wrapped %0d times",
                 verdict_tally[VERDICT_TTL_ZERO], verdict_tally[VERDICT_TTL_NEG], hist_wraps);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d verdicts still awaited", awaited_verdicts.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/fdf_pkg.sv
hdl/fdf_cell.sv
hdl/flood_duplicate_filter_top.sv
hdl/fdf_checker.sv
verif/tb_flood_duplicate_filter_top.sv
